/* hdl/plob_pkg.sv */
// ============================================================================
// plob_pkg
// Shared types, commands and status codes of the price level order book.
// ============================================================================
package plob_pkg;

    localparam int unsigned LevelsDefault = 64;
    localparam int unsigned PriceW = 32;
    localparam int unsigned QtyW   = 32;
    localparam int unsigned IdxW   = 7;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_TRADE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_PRICE  = 2'd1,
        ST_SHORT_QTY = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ACT_HOLD   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_UPDATE = 2'd2,
        ACT_DELETE = 2'd3
    } act_t;

    // Controller states of the core.
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_APPLY = 2'd1,
        S_OUT   = 2'd2
    } fsm_t;

    // Broadcast from the controller to every cell of one side.
    typedef struct packed {
        act_t              act;
        logic              is_ask;
        logic [PriceW-1:0] price;
        logic [QtyW-1:0]   qty;
    } cell_ctl_t;

    // Per-cell compare results sent back to the controller.
    typedef struct packed {
        logic match;
        logic behind;
    } cell_flag_t;

endpackage

/* hdl/price_level_order_book_core.sv */
// ============================================================================
// price_level_order_book_core
// Aggregated limit order book with sorted bid and ask level chains.
// ============================================================================
// Each command is one input transfer and yields exactly one result transfer.
// A command is taken while the core is idle, or in the same cycle that the
// pending result leaves. In the cycle after the input transfer every cell of
// the chosen side compares its price against the command price at once, the
// controller turns the match flags into one action for the side (update a
// level, insert and shift down, or delete and shift up), and at the end of
// that cycle the cells apply it, each taking data from a neighbor. In the
// following cycle the result, built from the updated chains, is presented
// and held until it is taken. With a receiver that is always ready and a
// sender that keeps tvalid high, the next command enters as the result
// leaves; back-pressure on the result delays it. Queries read the n-th cell
// by index. After reset the book is empty and can accept commands at once.
module price_level_order_book_core #(
    parameter int unsigned LEVELS_PER_SIDE = plob_pkg::LevelsDefault
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: cmd[1:0], side[2], price[34:3], quantity[66:35], level_index[73:67]
    input  logic [79:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: status[1:0], level_found[2], level_price[34:3], level_quantity[66:35],
    // best_bid_price[98:67], best_bid_quantity[130:99], best_ask_price[162:131],
    // best_ask_quantity[194:163], last_trade_price[226:195],
    // last_trade_quantity[258:227], book_empty[259]
    output logic [263:0] m_tdata
);
    import plob_pkg::*;

    localparam int unsigned LW = $clog2(LEVELS_PER_SIDE);

    fsm_t state_reg, state_next;

    logic              side_reg;
    cmd_t              cmd_reg;
    logic [PriceW-1:0] price_reg;
    logic [QtyW-1:0]   qty_reg;
    logic [IdxW-1:0]   idx_reg;
    status_t           status_reg, status_next;
    logic [PriceW-1:0] tp_reg;
    logic [QtyW-1:0]   tq_reg;

    cell_ctl_t bid_ctl, ask_ctl, ctl;
    logic [LEVELS_PER_SIDE-1:0] b_occ, a_occ, b_m, a_m;
    logic [LEVELS_PER_SIDE-1:0][PriceW-1:0] b_p, a_p;
    logic [LEVELS_PER_SIDE-1:0][QtyW-1:0]   b_q, a_q;

    logic [LEVELS_PER_SIDE-1:0] s_occ, s_m;
    logic [LEVELS_PER_SIDE-1:0][QtyW-1:0] s_q;
    logic              any_match, full;
    logic [QtyW-1:0]   mq;
    logic [QtyW:0]     sum;
    act_t              act_next;
    logic [QtyW-1:0]   ctl_qty;

    plob_side #(.LEVELS(LEVELS_PER_SIDE)) u_bid (
        .aclk(aclk), .aresetn(aresetn), .ctl(bid_ctl),
        .occ(b_occ), .price(b_p), .qty(b_q), .match(b_m));
    plob_side #(.LEVELS(LEVELS_PER_SIDE)) u_ask (
        .aclk(aclk), .aresetn(aresetn), .ctl(ask_ctl),
        .occ(a_occ), .price(a_p), .qty(a_q), .match(a_m));

    assign s_occ = side_reg ? a_occ : b_occ;
    assign s_m   = side_reg ? a_m   : b_m;
    assign s_q   = side_reg ? a_q   : b_q;
    assign any_match = |s_m;
    assign full      = s_occ[LEVELS_PER_SIDE-1];

    always_comb begin
        mq = '0;
        for (int i = 0; i < LEVELS_PER_SIDE; i++) begin
            mq = mq | (s_q[i] & {QtyW{s_m[i]}});
        end
    end
    assign sum = {1'b0, mq} + {1'b0, qty_reg};

    // Decide the side action from the compare flags.
    always_comb begin
        act_next    = ACT_HOLD;
        status_next = ST_OK;
        ctl_qty     = qty_reg;
        case (cmd_reg)
            CMD_ADD: begin
                if (any_match) begin
                    act_next = ACT_UPDATE;
                    ctl_qty  = sum[QtyW] ? {QtyW{1'b1}} : sum[QtyW-1:0];
                end else if (full) begin
                    status_next = ST_FULL;
                end else begin
                    act_next = ACT_INSERT;
                end
            end
            CMD_REMOVE: begin
                if (!any_match) begin
                    status_next = ST_NO_PRICE;
                end else if (mq < qty_reg) begin
                    status_next = ST_SHORT_QTY;
                end else if (mq == qty_reg) begin
                    act_next = ACT_DELETE;
                end else begin
                    act_next = ACT_UPDATE;
                    ctl_qty  = mq - qty_reg;
                end
            end
            default: begin
                act_next = ACT_HOLD;
            end
        endcase
    end

    assign ctl.act    = (state_reg == S_APPLY) ? act_next : ACT_HOLD;
    assign ctl.is_ask = side_reg;
    assign ctl.price  = price_reg;
    assign ctl.qty    = ctl_qty;
    always_comb begin
        bid_ctl = ctl;
        ask_ctl = ctl;
        if (side_reg) begin
            bid_ctl.act = ACT_HOLD;
        end else begin
            ask_ctl.act = ACT_HOLD;
        end
    end

    // The next command may follow directly on the result transfer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_tvalid)  state_next = S_APPLY;
            S_APPLY: state_next = S_OUT;
            S_OUT:   if (m_tready) state_next = s_tvalid ? S_APPLY : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
            end
            S_OUT: begin
                m_tvalid = 1'b1;
                s_tready = m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            tp_reg    <= '0;
            tq_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_APPLY && cmd_reg == CMD_TRADE) begin
                tp_reg <= price_reg;
                tq_reg <= qty_reg;
            end
        end
        if (s_tvalid && s_tready) begin
            cmd_reg   <= cmd_t'(s_tdata[1:0]);
            side_reg  <= s_tdata[2];
            price_reg <= s_tdata[34:3];
            qty_reg   <= s_tdata[66:35];
            idx_reg   <= s_tdata[73:67];
        end
        if (state_reg == S_APPLY) begin
            status_reg <= status_next;
        end
    end

    // Result built from the updated chains.
    logic              qf;
    logic [PriceW-1:0] qp;
    logic [QtyW-1:0]   qq;
    logic [LW-1:0]     qi;
    assign qi = LW'(idx_reg - 7'd1);
    always_comb begin
        qf = 1'b0;
        qp = '0;
        qq = '0;
        if (cmd_reg == CMD_QUERY && idx_reg != '0 &&
            32'(idx_reg) <= 32'(LEVELS_PER_SIDE) && s_occ[qi]) begin
            qf = 1'b1;
            qp = side_reg ? a_p[qi] : b_p[qi];
            qq = side_reg ? a_q[qi] : b_q[qi];
        end
    end

    assign m_tdata = {4'd0,
                      !(b_occ[0] || a_occ[0]),
                      tq_reg, tp_reg,
                      a_occ[0] ? a_q[0] : 32'd0, a_occ[0] ? a_p[0] : 32'd0,
                      b_occ[0] ? b_q[0] : 32'd0, b_occ[0] ? b_p[0] : 32'd0,
                      qq, qp, qf, status_reg};

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result stalled");
    a_full_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_APPLY && status_next == ST_FULL |-> cmd_reg == CMD_ADD)
        else $error("full status on non-add");
`endif

endmodule

/* hdl/plob_cell.sv */
// ============================================================================
// plob_cell
// One price level: compares against the broadcast price and shifts with its
// neighbors on insert or delete.
// ============================================================================
module plob_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  plob_pkg::cell_ctl_t           ctl,
    input  logic                          occ_in,
    input  logic                          prev_occ,
    input  logic                          prev_ins,
    input  logic [plob_pkg::PriceW-1:0]   prev_price,
    input  logic [plob_pkg::QtyW-1:0]     prev_qty,
    input  logic                          next_occ,
    input  logic [plob_pkg::PriceW-1:0]   next_price,
    input  logic [plob_pkg::QtyW-1:0]     next_qty,
    input  logic                          prev_gone,
    output logic                          occ,
    output logic                          ins_here,
    output logic [plob_pkg::PriceW-1:0]   price,
    output logic [plob_pkg::QtyW-1:0]     qty,
    output plob_pkg::cell_flag_t          flag,
    output logic                          gone
);
    import plob_pkg::*;

    logic              occ_reg, occ_next;
    logic [PriceW-1:0] price_reg, price_next;
    logic [QtyW-1:0]   qty_reg, qty_next;
    logic              behind;
    logic              ins_at;

    assign occ   = occ_reg;
    assign price = price_reg;
    assign qty   = qty_reg;
    assign behind = occ_reg &&
                    (ctl.is_ask ? (ctl.price < price_reg) : (ctl.price > price_reg));
    assign flag.match  = occ_reg && (price_reg == ctl.price);
    assign flag.behind = behind;
    // The new level lands in the first cell it ranks ahead of, or the first free one.
    assign ins_at   = (behind || !occ_reg) && !prev_ins && prev_occ;
    assign ins_here = prev_ins || ins_at;
    // Cells at and after the matched one pull from their right neighbor.
    assign gone = prev_gone || flag.match;

    always_comb begin
        occ_next   = occ_reg;
        price_next = price_reg;
        qty_next   = qty_reg;
        case (ctl.act)
            ACT_INSERT: begin
                if (prev_ins) begin
                    occ_next   = prev_occ;
                    price_next = prev_price;
                    qty_next   = prev_qty;
                end else if (ins_at) begin
                    occ_next   = 1'b1;
                    price_next = ctl.price;
                    qty_next   = ctl.qty;
                end
            end
            ACT_UPDATE: begin
                if (flag.match) begin
                    qty_next = ctl.qty;
                end
            end
            ACT_DELETE: begin
                if (gone) begin
                    occ_next   = next_occ;
                    price_next = next_price;
                    qty_next   = next_qty;
                end
            end
            default: begin
                occ_next = occ_reg;
            end
        endcase
        if (!occ_in) begin
            occ_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
        price_reg <= price_next;
        qty_reg   <= qty_next;
    end

endmodule

/* hdl/plob_side.sv */
// ============================================================================
// plob_side
// One side of the book: a chain of level cells, best level in cell zero.
// ============================================================================
module plob_side #(
    parameter int unsigned LEVELS = plob_pkg::LevelsDefault
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  plob_pkg::cell_ctl_t                ctl,
    output logic [LEVELS-1:0]                  occ,
    output logic [LEVELS-1:0][plob_pkg::PriceW-1:0] price,
    output logic [LEVELS-1:0][plob_pkg::QtyW-1:0]   qty,
    output logic [LEVELS-1:0]                  match
);
    import plob_pkg::*;

    logic [LEVELS:0] ins_chain;
    logic [LEVELS:0] gone_chain;
    logic [LEVELS:0] occ_chain;

    assign ins_chain[0]  = 1'b0;
    assign gone_chain[0] = 1'b0;
    assign occ_chain[0]  = 1'b1;

    for (genvar g = 0; g < LEVELS; g++) begin : g_cell
        cell_flag_t fl;
        logic              n_occ;
        logic [PriceW-1:0] n_price;
        logic [QtyW-1:0]   n_qty;
        if (g == LEVELS - 1) begin : g_end
            assign n_occ   = 1'b0;
            assign n_price = '0;
            assign n_qty   = '0;
        end else begin : g_mid
            assign n_occ   = occ[g+1];
            assign n_price = price[g+1];
            assign n_qty   = qty[g+1];
        end
        plob_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .occ_in     (1'b1),
            .prev_occ   (occ_chain[g]),
            .prev_ins   (ins_chain[g]),
            .prev_price ((g == 0) ? '0 : price[(g == 0) ? 0 : g-1]),
            .prev_qty   ((g == 0) ? '0 : qty[(g == 0) ? 0 : g-1]),
            .next_occ   (n_occ),
            .next_price (n_price),
            .next_qty   (n_qty),
            .prev_gone  (gone_chain[g]),
            .occ        (occ[g]),
            .ins_here   (ins_chain[g+1]),
            .price      (price[g]),
            .qty        (qty[g]),
            .flag       (fl),
            .gone       (gone_chain[g+1])
        );
        assign match[g]      = fl.match;
        assign occ_chain[g+1] = occ[g];
    end

endmodule
